// ----- src/brr_pkg.sv -----
package brr_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 512;
  localparam int unsigned DEF_MAX_HEIGHT = 512;
  localparam int unsigned DEF_FRAC_BITS  = 16;

  localparam int unsigned COORD_W = 9;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned SIZE_W  = 10;
  localparam int unsigned STEP_W  = 26;
  localparam int unsigned Q_SHIFT = 16;
  localparam int unsigned POS_W   = COORD_W + STEP_W;
  localparam int unsigned CFG_AW  = 4;
  localparam int unsigned CFG_DW  = 32;
  localparam int unsigned CHAN_MAX = (1 << CHAN_W) - 1;

  localparam logic [SIZE_W-1:0] SIZE_RST = SIZE_W'(512);
  localparam logic [STEP_W-1:0] STEP_RST = STEP_W'(65536);

  typedef enum logic [1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_X_STEP     = 2'd2,
    REG_Y_STEP     = 2'd3
  } reg_idx_e;

  typedef enum logic {
    FUNC_WRITE  = 1'b0,
    FUNC_SAMPLE = 1'b1
  } func_e;

  // Index 2 is red, 1 is green, 0 is blue.
  typedef logic [2:0][CHAN_W-1:0] pixel_t;

endpackage

// ----- src/bilinear_rgb_resize_core.sv -----
// Bilinear RGB888 resize core with an on-chip source frame store.
// Input channel: an item is taken at a rising edge where start is high and busy
// is low. busy is always low, so one item can be taken in every cycle. With
// func_i low the item writes one source pixel at (column_i, line_i); with
// func_i high it samples the destination pixel at (column_i, line_i).
// Output channel: each sample item gives one word on red_out_o, green_out_o
// and blue_out_o, marked by valid_o for exactly one cycle. valid_o is driven
// from the output register at the end of the pipeline. Write items give no
// word. Throughput is one item per clock. The pipeline has five stages: step
// multiply, coordinate clamp, frame-store read with weight multiply, channel
// multiply, and the rounded sum. The store is split into four banks by row
// and column parity, so the four neighbors of a sample are read in the same
// cycle. Writes and reads reach the banks in the same stage, so items act in
// the order they were taken.
// The receiver cannot hold words off, and the core never stalls.
// Reset clears the pipeline valid bits and the registers (source size 512 by
// 512, unit steps). The frame store is not cleared: a pixel must be written
// before a sample reads it. The user must write registers over the APB port
// only while no item is in flight; the core itself does not enforce this.
module bilinear_rgb_resize_core #(
  parameter int unsigned MAX_WIDTH  = brr_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = brr_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned FRAC_BITS  = brr_pkg::DEF_FRAC_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         func_i,
  input  logic [brr_pkg::COORD_W-1:0]  column_i,
  input  logic [brr_pkg::COORD_W-1:0]  line_i,
  input  logic [brr_pkg::CHAN_W-1:0]   red_in_i,
  input  logic [brr_pkg::CHAN_W-1:0]   green_in_i,
  input  logic [brr_pkg::CHAN_W-1:0]   blue_in_i,
  output logic                         valid_o,
  output logic [brr_pkg::CHAN_W-1:0]   red_out_o,
  output logic [brr_pkg::CHAN_W-1:0]   green_out_o,
  output logic [brr_pkg::CHAN_W-1:0]   blue_out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [brr_pkg::CFG_AW-1:0]   paddr,
  input  logic [brr_pkg::CFG_DW-1:0]   pwdata,
  output logic [brr_pkg::CFG_DW-1:0]   prdata,
  output logic                         pready
);
  import brr_pkg::*;

  localparam int unsigned XW         = $clog2(MAX_WIDTH);
  localparam int unsigned YW         = $clog2(MAX_HEIGHT);
  localparam int unsigned IPW        = POS_W - Q_SHIFT;
  localparam int unsigned BANK_W     = (MAX_WIDTH + 1) / 2;
  localparam int unsigned BANK_H     = (MAX_HEIGHT + 1) / 2;
  localparam int unsigned BANK_DEPTH = BANK_W * BANK_H;
  localparam int unsigned BAW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int unsigned ONE_W      = FRAC_BITS + 1;
  localparam int unsigned MUL_W      = 2 * ONE_W;
  localparam int unsigned WGT_W      = 2 * FRAC_BITS + 1;
  localparam int unsigned PRD_W      = WGT_W + CHAN_W;
  localparam int unsigned ACC_W      = PRD_W + 2;
  localparam int unsigned RES_W      = ACC_W - 2 * FRAC_BITS;

  // Configuration registers.
  logic [SIZE_W-1:0] src_width_q, src_height_q;
  logic [STEP_W-1:0] x_step_q, y_step_q;
  logic              cfg_we;
  reg_idx_e          cfg_idx;

  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= SIZE_RST;
      src_height_q <= SIZE_RST;
      x_step_q     <= STEP_RST;
      y_step_q     <= STEP_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SRC_WIDTH:  src_width_q  <= pwdata[SIZE_W-1:0];
        REG_SRC_HEIGHT: src_height_q <= pwdata[SIZE_W-1:0];
        REG_X_STEP:     x_step_q     <= pwdata[STEP_W-1:0];
        REG_Y_STEP:     y_step_q     <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SRC_WIDTH:  prdata = CFG_DW'(src_width_q);
      REG_SRC_HEIGHT: prdata = CFG_DW'(src_height_q);
      REG_X_STEP:     prdata = CFG_DW'(x_step_q);
      REG_Y_STEP:     prdata = CFG_DW'(y_step_q);
      default:        prdata = '0;
    endcase
  end

  // Stage 1: step multiply.
  logic              in_acc;
  logic [POS_W-1:0]  pos_x_d, pos_y_d;
  logic              inside_d;
  logic              s1_valid_q, s1_func_q, s1_inside_q;
  logic [POS_W-1:0]  s1_pos_x_q, s1_pos_y_q;
  logic [COORD_W-1:0] s1_col_q, s1_row_q;
  pixel_t            s1_pix_q;

  assign busy     = 1'b0;
  assign in_acc   = start & ~busy;
  assign pos_x_d  = POS_W'(column_i) * POS_W'(x_step_q);
  assign pos_y_d  = POS_W'(line_i) * POS_W'(y_step_q);
  assign inside_d = (32'(column_i) < MAX_WIDTH) && (32'(line_i) < MAX_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_func_q   <= func_i;
    s1_inside_q <= inside_d;
    s1_pos_x_q  <= pos_x_d;
    s1_pos_y_q  <= pos_y_d;
    s1_col_q    <= column_i;
    s1_row_q    <= line_i;
    s1_pix_q    <= {red_in_i, green_in_i, blue_in_i};
  end

  // Stage 2: integer part, fraction and edge clamp.
  logic [IPW-1:0]       w_size, h_size, ip_x, ip_y, x0_full, y0_full, x1_full, y1_full;
  logic [FRAC_BITS-1:0] fx_d, fy_d;
  logic [XW-1:0]        x0_d, x1_d;
  logic [YW-1:0]        y0_d, y1_d;
  logic                 s2_sample_q, s2_we_q;
  logic [XW-1:0]        s2_x0_q, s2_x1_q;
  logic [YW-1:0]        s2_y0_q, s2_y1_q;
  logic [FRAC_BITS-1:0] s2_fx_q, s2_fy_q;
  pixel_t               s2_pix_q;

  always_comb begin
    if (src_width_q == '0) begin
      w_size = IPW'(1);
    end else if (IPW'(src_width_q) > IPW'(MAX_WIDTH)) begin
      w_size = IPW'(MAX_WIDTH);
    end else begin
      w_size = IPW'(src_width_q);
    end
    if (src_height_q == '0) begin
      h_size = IPW'(1);
    end else if (IPW'(src_height_q) > IPW'(MAX_HEIGHT)) begin
      h_size = IPW'(MAX_HEIGHT);
    end else begin
      h_size = IPW'(src_height_q);
    end

    ip_x = s1_pos_x_q[POS_W-1:Q_SHIFT];
    ip_y = s1_pos_y_q[POS_W-1:Q_SHIFT];
    fx_d = s1_pos_x_q[Q_SHIFT-1 -: FRAC_BITS];
    fy_d = s1_pos_y_q[Q_SHIFT-1 -: FRAC_BITS];
    x0_full = ip_x;
    y0_full = ip_y;
    if (ip_x >= w_size) begin
      x0_full = w_size - IPW'(1);
      fx_d    = '0;
    end
    if (ip_y >= h_size) begin
      y0_full = h_size - IPW'(1);
      fy_d    = '0;
    end
    x1_full = (x0_full + IPW'(1) < w_size) ? x0_full + IPW'(1) : x0_full;
    y1_full = (y0_full + IPW'(1) < h_size) ? y0_full + IPW'(1) : y0_full;

    if (s1_func_q == FUNC_WRITE) begin
      x0_d = XW'(s1_col_q);
      x1_d = XW'(s1_col_q);
      y0_d = YW'(s1_row_q);
      y1_d = YW'(s1_row_q);
    end else begin
      x0_d = x0_full[XW-1:0];
      x1_d = x1_full[XW-1:0];
      y0_d = y0_full[YW-1:0];
      y1_d = y1_full[YW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_sample_q <= 1'b0;
      s2_we_q     <= 1'b0;
    end else begin
      s2_sample_q <= s1_valid_q && (s1_func_q == FUNC_SAMPLE);
      s2_we_q     <= s1_valid_q && (s1_func_q == FUNC_WRITE) && s1_inside_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_x0_q  <= x0_d;
    s2_x1_q  <= x1_d;
    s2_y0_q  <= y0_d;
    s2_y1_q  <= y1_d;
    s2_fx_q  <= fx_d;
    s2_fy_q  <= fy_d;
    s2_pix_q <= s1_pix_q;
  end

  // Stage 3: banked frame store access and weight products.
  logic [3:0]           bank_we;
  logic [BAW-1:0]       bank_addr [4];
  pixel_t               bank_rd_q [4];
  logic [ONE_W-1:0]     omx, omy;
  logic [MUL_W-1:0]     w00_full, w01_full, w10_full, w11_full;
  logic                 s3_valid_q;
  logic                 s3_x0p_q, s3_x1p_q, s3_y0p_q, s3_y1p_q;
  logic [WGT_W-1:0]     s3_w_q [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic PX = 1'(b % 2);
    localparam logic PY = 1'(b / 2);
    logic [XW-1:0] cx;
    logic [YW-1:0] cy;
    pixel_t        mem [BANK_DEPTH];

    assign cx = (s2_x0_q[0] == PX) ? s2_x0_q : s2_x1_q;
    assign cy = (s2_y0_q[0] == PY) ? s2_y0_q : s2_y1_q;
    assign bank_addr[b] = BAW'((32'(cy) >> 1) * BANK_W + (32'(cx) >> 1));
    assign bank_we[b]   = s2_we_q && (s2_x0_q[0] == PX) && (s2_y0_q[0] == PY);

    always_ff @(posedge clk_i) begin
      if (bank_we[b]) begin
        mem[bank_addr[b]] <= s2_pix_q;
      end
      bank_rd_q[b] <= mem[bank_addr[b]];
    end
  end

  assign omx      = (ONE_W'(1) << FRAC_BITS) - ONE_W'(s2_fx_q);
  assign omy      = (ONE_W'(1) << FRAC_BITS) - ONE_W'(s2_fy_q);
  assign w00_full = MUL_W'(omx) * MUL_W'(omy);
  assign w01_full = MUL_W'(s2_fx_q) * MUL_W'(omy);
  assign w10_full = MUL_W'(omx) * MUL_W'(s2_fy_q);
  assign w11_full = MUL_W'(s2_fx_q) * MUL_W'(s2_fy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_sample_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_x0p_q  <= s2_x0_q[0];
    s3_x1p_q  <= s2_x1_q[0];
    s3_y0p_q  <= s2_y0_q[0];
    s3_y1p_q  <= s2_y1_q[0];
    s3_w_q[0] <= w00_full[WGT_W-1:0];
    s3_w_q[1] <= w01_full[WGT_W-1:0];
    s3_w_q[2] <= w10_full[WGT_W-1:0];
    s3_w_q[3] <= w11_full[WGT_W-1:0];
  end

  // Stage 4: neighbor select and channel products.
  pixel_t           nb [4];
  logic [PRD_W-1:0] prd_d  [3][4];
  logic [PRD_W-1:0] s4_prd_q [3][4];
  logic             s4_valid_q;

  always_comb begin
    nb[0] = bank_rd_q[{s3_y0p_q, s3_x0p_q}];
    nb[1] = bank_rd_q[{s3_y0p_q, s3_x1p_q}];
    nb[2] = bank_rd_q[{s3_y1p_q, s3_x0p_q}];
    nb[3] = bank_rd_q[{s3_y1p_q, s3_x1p_q}];
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 4; k++) begin
        prd_d[c][k] = PRD_W'(nb[k][c]) * PRD_W'(s3_w_q[k]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_prd_q <= prd_d;
  end

  // Stage 5: sum, round half up and saturate.
  logic [ACC_W-1:0] acc [3];
  logic [RES_W-1:0] res [3];
  pixel_t           out_d;
  pixel_t           out_q;
  logic             out_valid_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc[c] = ACC_W'(s4_prd_q[c][0]) + ACC_W'(s4_prd_q[c][1]) +
               ACC_W'(s4_prd_q[c][2]) + ACC_W'(s4_prd_q[c][3]) +
               (ACC_W'(1) << (2 * FRAC_BITS - 1));
      res[c] = acc[c][ACC_W-1:2*FRAC_BITS];
      out_d[c] = (res[c] > RES_W'(CHAN_MAX)) ? CHAN_W'(CHAN_MAX) : res[c][CHAN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign valid_o     = out_valid_q;
  assign red_out_o   = out_q[2];
  assign green_out_o = out_q[1];
  assign blue_out_o  = out_q[0];

  // Every sample item gives an output word at the end of the pipeline.
  a_sample_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (func_i == FUNC_SAMPLE)) |-> ##5 valid_o)
    else $error("sample item gave no output word");

  a_word_has_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(in_acc && (func_i == FUNC_SAMPLE), 5))
    else $error("output word without a sample item");

  a_one_bank_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(bank_we))
    else $error("more than one bank written in a cycle");

  a_weights_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q |-> ((64'(s3_w_q[0]) + 64'(s3_w_q[1]) + 64'(s3_w_q[2]) +
                     64'(s3_w_q[3])) == (64'(1) << (2 * FRAC_BITS))))
    else $error("bilinear weights do not sum to one");

endmodule

// ----- tb/brr_resize_checker.sv -----
module brr_resize_checker #(
  parameter int unsigned MAX_WIDTH  = brr_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = brr_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned FRAC_BITS  = brr_pkg::DEF_FRAC_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        busy_i,
  input  logic                        func_i,
  input  logic [brr_pkg::COORD_W-1:0] column_i,
  input  logic [brr_pkg::COORD_W-1:0] line_i,
  input  logic [brr_pkg::CHAN_W-1:0]  red_in_i,
  input  logic [brr_pkg::CHAN_W-1:0]  green_in_i,
  input  logic [brr_pkg::CHAN_W-1:0]  blue_in_i,
  input  logic                        valid_i,
  input  logic [brr_pkg::CHAN_W-1:0]  red_out_i,
  input  logic [brr_pkg::CHAN_W-1:0]  green_out_i,
  input  logic [brr_pkg::CHAN_W-1:0]  blue_out_i,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic                        pready_i,
  input  logic [brr_pkg::CFG_AW-1:0]  paddr_i,
  input  logic [brr_pkg::CFG_DW-1:0]  pwdata_i,
  output int unsigned                 fail_count_o,
  output int unsigned                 pending_o
);
  import brr_pkg::*;

  localparam int unsigned STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam logic [63:0] ONE_Q = 64'd1 << FRAC_BITS;
  localparam logic [63:0] HALF_LSB = 64'd1 << (2 * FRAC_BITS - 1);

  pixel_t            source_mem [STORE_DEPTH];
  logic [SIZE_W-1:0] width_reg;
  logic [SIZE_W-1:0] height_reg;
  logic [STEP_W-1:0] x_step;
  logic [STEP_W-1:0] y_step;
  pixel_t            resized_q [$];
  pixel_t            want;
  pixel_t            got;
  int unsigned       errors;
  string             chan_name [3] = '{"blue", "green", "red"};

  function automatic int unsigned size_in_use(logic [SIZE_W-1:0] v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic void split_axis(input logic [COORD_W-1:0] idx,
                                     input logic [STEP_W-1:0] step,
                                     input int unsigned size,
                                     output int unsigned lo, output int unsigned hi,
                                     output logic [63:0] frac);
    logic [63:0] pos;
    pos = 64'(idx) * 64'(step);
    frac = 64'(pos[Q_SHIFT-1:0]) >> (Q_SHIFT - FRAC_BITS);
    if ((pos >> Q_SHIFT) >= 64'(size)) begin
      lo = size - 1;
      frac = '0;
    end else begin
      lo = 32'(pos >> Q_SHIFT);
    end
    hi = (lo + 1 < size) ? lo + 1 : lo;
  endfunction

  function automatic pixel_t resized_pixel(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
    int unsigned x0, x1, y0, y1;
    logic [63:0] fx, fy, w00, w01, w10, w11, acc;
    pixel_t p00, p01, p10, p11, res;
    split_axis(col, x_step, size_in_use(width_reg, MAX_WIDTH), x0, x1, fx);
    split_axis(row, y_step, size_in_use(height_reg, MAX_HEIGHT), y0, y1, fy);
    p00 = source_mem[y0 * MAX_WIDTH + x0];
    p01 = source_mem[y0 * MAX_WIDTH + x1];
    p10 = source_mem[y1 * MAX_WIDTH + x0];
    p11 = source_mem[y1 * MAX_WIDTH + x1];
    w00 = (ONE_Q - fx) * (ONE_Q - fy);
    w01 = fx * (ONE_Q - fy);
    w10 = (ONE_Q - fx) * fy;
    w11 = fx * fy;
    for (int c = 0; c < 3; c++) begin
      acc = 64'(p00[c]) * w00 + 64'(p01[c]) * w01 + 64'(p10[c]) * w10 + 64'(p11[c]) * w11;
      acc = (acc + HALF_LSB) >> (2 * FRAC_BITS);
      res[c] = (acc > CHAN_MAX) ? CHAN_W'(CHAN_MAX) : acc[CHAN_W-1:0];
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg = SIZE_RST;
      height_reg = SIZE_RST;
      x_step = STEP_RST;
      y_step = STEP_RST;
      resized_q.delete();
      errors = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (valid_i) begin
        got = {red_out_i, green_out_i, blue_out_i};
        if (resized_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word: expected none, actual %h", $time, got);
        end else begin
          want = resized_q.pop_front();
          for (int c = 2; c >= 0; c--) begin
            if (got[c] !== want[c]) begin
              errors++;
              $display("%0t: %s mismatch: expected %0d, actual %0d",
                       $time, chan_name[c], want[c], got[c]);
            end
          end
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[CFG_AW-1:2]))
          REG_SRC_WIDTH:  width_reg = pwdata_i[SIZE_W-1:0];
          REG_SRC_HEIGHT: height_reg = pwdata_i[SIZE_W-1:0];
          REG_X_STEP:     x_step = pwdata_i[STEP_W-1:0];
          REG_Y_STEP:     y_step = pwdata_i[STEP_W-1:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        if (func_e'(func_i) == FUNC_WRITE) begin
          if (column_i < MAX_WIDTH && line_i < MAX_HEIGHT) begin
            source_mem[line_i * MAX_WIDTH + column_i] = {red_in_i, green_in_i, blue_in_i};
          end
        end else begin
          resized_q.push_back(resized_pixel(column_i, line_i));
        end
      end
      fail_count_o <= errors;
      pending_o <= resized_q.size();
    end
  end

endmodule

// ----- tb/tb_bilinear_rgb_resize_core.sv -----
module tb_bilinear_rgb_resize_core;
  import brr_pkg::*;

  localparam int unsigned MAX_W = DEF_MAX_WIDTH;
  localparam int unsigned MAX_H = DEF_MAX_HEIGHT;
  localparam int unsigned RANDOM_ITEMS = 550;
  localparam int unsigned CALM_ITEMS = 100;
  localparam int unsigned LATENCY_PAUSE = 8;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned STALL_LIMIT = 2000;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               func;
  logic [COORD_W-1:0] column;
  logic [COORD_W-1:0] row;
  logic [CHAN_W-1:0]  red_in, green_in, blue_in;
  logic               valid;
  logic [CHAN_W-1:0]  red_out, green_out, blue_out;
  logic               psel, penable, pwrite, pready;
  logic [CFG_AW-1:0]  paddr;
  logic [CFG_DW-1:0]  pwdata, prdata;
  int unsigned        fail_count;
  int unsigned        pending;
  int unsigned        stall_cycles;

  logic [SIZE_W-1:0] cfg_width;
  logic [SIZE_W-1:0] cfg_height;
  logic [STEP_W-1:0] cfg_x_step;
  logic [STEP_W-1:0] cfg_y_step;
  bit                written [MAX_W * MAX_H];
  bit                idling;
  int unsigned       items_done;

  always begin
    #6 clk = 1'b0;
    #6 clk = 1'b1;
  end

  bilinear_rgb_resize_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start       (start),
    .busy        (busy),
    .func_i      (func),
    .column_i    (column),
    .line_i      (row),
    .red_in_i    (red_in),
    .green_in_i  (green_in),
    .blue_in_i   (blue_in),
    .valid_o     (valid),
    .red_out_o   (red_out),
    .green_out_o (green_out),
    .blue_out_o  (blue_out),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  brr_resize_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_i       (busy),
    .func_i       (func),
    .column_i     (column),
    .line_i       (row),
    .red_in_i     (red_in),
    .green_in_i   (green_in),
    .blue_in_i    (blue_in),
    .valid_i      (valid),
    .red_out_i    (red_out),
    .green_out_i  (green_out),
    .blue_out_i   (blue_out),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk) begin
    if ((start && !busy) || valid || (psel && penable && pwrite && pready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_bilinear_rgb_resize_core NOT OK");
      $finish;
    end
  end

  function automatic int unsigned size_in_use(logic [SIZE_W-1:0] v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // Integer source neighbors that a destination index reaches on one axis.
  function automatic void source_span(input int unsigned idx, input logic [STEP_W-1:0] step,
                                      input int unsigned size,
                                      output int unsigned lo, output int unsigned hi);
    logic [63:0] ip;
    ip = (64'(idx) * 64'(step)) >> Q_SHIFT;
    lo = (ip >= 64'(size)) ? size - 1 : 32'(ip);
    hi = (lo + 1 < size) ? lo + 1 : lo;
  endfunction

  task automatic idle_cycles(int unsigned n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic send_item(func_e f, int unsigned col, int unsigned r, pixel_t pix);
    if (idling && $urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 7));
    @(negedge clk);
    start <= 1'b1;
    func <= f;
    column <= COORD_W'(col);
    row <= COORD_W'(r);
    red_in <= pix[2];
    green_in <= pix[1];
    blue_in <= pix[0];
    do @(posedge clk); while (busy);
    items_done++;
  endtask

  task automatic store_pixel(int unsigned col, int unsigned r, pixel_t pix);
    send_item(FUNC_WRITE, col, r, pix);
    written[r * MAX_W + col] = 1'b1;
  endtask

  // Any neighbor not yet stored is written first, so no sample reads an empty entry.
  task automatic sample_at(int unsigned col, int unsigned r);
    int unsigned xs [2];
    int unsigned ys [2];
    source_span(col, cfg_x_step, size_in_use(cfg_width, MAX_W), xs[0], xs[1]);
    source_span(r, cfg_y_step, size_in_use(cfg_height, MAX_H), ys[0], ys[1]);
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        if (!written[ys[i] * MAX_W + xs[j]]) store_pixel(xs[j], ys[i], pixel_t'($urandom));
      end
    end
    send_item(FUNC_SAMPLE, col, r, pixel_t'($urandom));
  endtask

  task automatic apb_write(reg_idx_e idx, logic [CFG_DW-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic set_config(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h,
                            logic [STEP_W-1:0] xs, logic [STEP_W-1:0] ys);
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY_PAUSE) @(posedge clk);
    apb_write(REG_SRC_WIDTH, CFG_DW'(w));
    apb_write(REG_SRC_HEIGHT, CFG_DW'(h));
    apb_write(REG_X_STEP, CFG_DW'(xs));
    apb_write(REG_Y_STEP, CFG_DW'(ys));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    cfg_width = w;
    cfg_height = h;
    cfg_x_step = xs;
    cfg_y_step = ys;
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return SIZE_W'(MAX_W);
      2: return '1;
      3: return SIZE_W'($urandom_range(0, 1023));
      default: return SIZE_W'($urandom_range(1, 20));
    endcase
  endfunction

  function automatic logic [STEP_W-1:0] pick_step();
    case ($urandom_range(0, 19))
      0, 1: return '0;
      2, 3: return STEP_W'(1 << 25);
      4: return STEP_W'($urandom);
      5, 6, 7: return STEP_W'($urandom_range(0, 1 << 25));
      8, 9, 10, 11: return STEP_RST;
      default: return STEP_W'($urandom_range(16'h4000, 20'h30000));
    endcase
  endfunction

  // Destination index, mostly kept where the source position lands inside the image.
  function automatic int unsigned pick_dest(logic [STEP_W-1:0] step, int unsigned size);
    logic [63:0] span;
    span = (step == 0) ? 64'd511 : ((64'(size) << Q_SHIFT) / 64'(step)) + 1;
    if (span > 511) span = 511;
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, 511);
    return $urandom_range(0, 32'(span));
  endfunction

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    func = FUNC_WRITE;
    column = '0;
    row = '0;
    red_in = '0;
    green_in = '0;
    blue_in = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cfg_width = SIZE_RST;
    cfg_height = SIZE_RST;
    cfg_x_step = STEP_RST;
    cfg_y_step = STEP_RST;
    idling = 1'b0;
    items_done = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: unit steps, so samples return stored pixels.
    store_pixel(0, 0, 24'hFF00FF);
    store_pixel(511, 511, 24'h00FF00);
    sample_at(0, 0);
    sample_at(511, 511);

    // Half steps give exact halves that round up; the last column and row clamp.
    set_config(3, 2, 26'h8000, 26'h8000);
    store_pixel(0, 0, 24'h000000);
    store_pixel(1, 0, 24'h010101);
    store_pixel(2, 0, 24'hFFFFFF);
    store_pixel(0, 1, 24'h000000);
    store_pixel(1, 1, 24'h010101);
    store_pixel(2, 1, 24'hFF00FF);
    sample_at(1, 0);
    sample_at(1, 1);
    sample_at(3, 0);
    sample_at(5, 3);
    sample_at(511, 511);

    // Zero sizes act as one pixel; a zero step and a step of 512.
    set_config(0, 0, '0, 26'h2000000);
    sample_at(0, 0);
    sample_at(7, 0);
    sample_at(511, 511);

    // Oversized sizes saturate; largest step and a fraction just below one.
    set_config('1, 10'd600, '1, 26'hFFFF);
    sample_at(1, 1);
    sample_at(0, 1);
    sample_at(511, 0);

    while (items_done < RANDOM_ITEMS) begin
      set_config(pick_size(), pick_size(), pick_step(), pick_step());
      idling = (items_done + CALM_ITEMS < RANDOM_ITEMS) && ($urandom_range(0, 3) != 0);
      for (int n = $urandom_range(60, 110); n > 0 && items_done < RANDOM_ITEMS; n--) begin
        if (items_done + CALM_ITEMS >= RANDOM_ITEMS) idling = 1'b0;
        if ($urandom_range(0, 3) == 0) begin
          store_pixel($urandom_range(0, 511), $urandom_range(0, 511), pixel_t'($urandom));
        end else begin
          sample_at(pick_dest(cfg_x_step, size_in_use(cfg_width, MAX_W)),
                    pick_dest(cfg_y_step, size_in_use(cfg_height, MAX_H)));
        end
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_bilinear_rgb_resize_core OK");
    end else begin
      $display("tb_bilinear_rgb_resize_core NOT OK");
    end
    $finish;
  end

endmodule
